// ===== src/swpf_pkg.sv =====
// Shared types and constants for the servo write packet framer.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package swpf_pkg;

  localparam int unsigned IdxW = 4;

  // Fixed packet bytes
  localparam logic [7:0] HDR_FF    = 8'hFF;
  localparam logic [7:0] HDR_FD    = 8'hFD;
  localparam logic [7:0] HDR_RSV   = 8'h00;
  localparam logic [7:0] LEN_NARROW = 8'h06;
  localparam logic [7:0] LEN_WIDE   = 8'h09;
  localparam logic [7:0] LEN_HI     = 8'h00;
  localparam logic [7:0] INST_WRITE = 8'h03;
  localparam logic [15:0] CRC_POLY  = 16'h8005;
  localparam logic [15:0] CRC_INIT  = 16'h0000;

  // Byte positions within the packet
  localparam logic [IdxW-1:0] POS_HDR0    = 4'd0;
  localparam logic [IdxW-1:0] POS_HDR1    = 4'd1;
  localparam logic [IdxW-1:0] POS_HDR2    = 4'd2;
  localparam logic [IdxW-1:0] POS_HDR3    = 4'd3;
  localparam logic [IdxW-1:0] POS_ID      = 4'd4;
  localparam logic [IdxW-1:0] POS_LEN_LO  = 4'd5;
  localparam logic [IdxW-1:0] POS_LEN_HI  = 4'd6;
  localparam logic [IdxW-1:0] POS_INST    = 4'd7;
  localparam logic [IdxW-1:0] POS_ADDR_LO = 4'd8;
  localparam logic [IdxW-1:0] POS_ADDR_HI = 4'd9;
  localparam logic [IdxW-1:0] POS_VAL0    = 4'd10;
  localparam logic [IdxW-1:0] POS_VAL1    = 4'd11;
  localparam logic [IdxW-1:0] POS_VAL2    = 4'd12;
  localparam logic [IdxW-1:0] POS_VAL3    = 4'd13;
  localparam logic [IdxW-1:0] POS_CRC_NARROW = 4'd11;
  localparam logic [IdxW-1:0] POS_CRC_WIDE   = 4'd14;
  localparam logic [IdxW-1:0] POS_END_NARROW = 4'd12;
  localparam logic [IdxW-1:0] POS_END_WIDE   = 4'd15;

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic start;  // capture command, restart byte counter and CRC
    logic load;   // move next packet byte into the output register
  } swpf_cmd_t;

  typedef struct packed {
    logic final_byte;  // byte at the counter is the packet's last
  } swpf_sts_t;

endpackage

// ===== src/swpf_ctrl.sv =====
// Controller FSM for the packet framer: input handshake, output valid, sequencing.
// Depends on swpf_pkg.
`timescale 1ns / 1ps

module swpf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output swpf_pkg::swpf_cmd_t cmd,
  input  swpf_pkg::swpf_sts_t sts
);
  import swpf_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
        if (in_valid) state_nxt = ST_SEND;
      end
      ST_SEND: begin
        // output slot free or being drained this cycle
        cmd.load = !out_valid_r || out_ready;
        if (cmd.load && sts.final_byte) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (cmd.load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_start_load_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.start && cmd.load))
    else $error("start and load in the same cycle");

  a_final_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && sts.final_byte) |=> (state_r == ST_IDLE) && out_valid_r)
    else $error("final byte did not return controller to idle");

  a_start_to_send: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> (state_r == ST_SEND))
    else $error("accepted command did not start sending");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !cmd.load)
    else $error("output register overwritten while stalled");
`endif

endmodule

// ===== src/swpf_dp.sv =====
// Datapath for the packet framer: command capture, id register, byte select,
// running CRC-16 and output byte register. Depends on swpf_pkg.
`timescale 1ns / 1ps

module swpf_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_servo_id,
  input  logic                in_op,
  input  logic [15:0]         in_reg_address,
  input  logic signed [31:0]  in_write_value,
  output logic [7:0]          out_tx_byte,
  output logic                out_last,
  input  swpf_pkg::swpf_cmd_t cmd,
  output swpf_pkg::swpf_sts_t sts
);
  import swpf_pkg::*;

  logic [7:0]      servo_id_r;
  logic            op_r;
  logic [15:0]     addr_r;
  logic [31:0]     val_r;
  logic [IdxW-1:0] idx_r, idx_nxt;
  logic [15:0]     crc_r, crc_nxt;
  logic [7:0]      tx_byte_r;
  logic            last_r;

  logic [IdxW-1:0] crc_pos;
  logic [IdxW-1:0] end_pos;
  logic [7:0]      cur_byte;
  logic [7:0]      data_byte;
  logic            in_crc;

  // One byte of CRC-16, MSB first, no reflection
  function automatic logic [15:0] crc_step(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      servo_id_r <= 8'h00;
    end else if (cfg_wr_en) begin
      servo_id_r <= cfg_servo_id;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r   <= in_op;
      addr_r <= in_reg_address;
      val_r  <= in_write_value;
    end
    idx_r <= idx_nxt;
    crc_r <= crc_nxt;
    if (cmd.load) begin
      tx_byte_r <= cur_byte;
      last_r    <= sts.final_byte;
    end
  end

  assign crc_pos = op_r ? POS_CRC_WIDE : POS_CRC_NARROW;
  assign end_pos = op_r ? POS_END_WIDE : POS_END_NARROW;
  assign in_crc  = (idx_r >= crc_pos);
  assign sts.final_byte = (idx_r == end_pos);

  always_comb begin
    unique case (idx_r)
      POS_HDR0, POS_HDR1: data_byte = HDR_FF;
      POS_HDR2:           data_byte = HDR_FD;
      POS_HDR3:           data_byte = HDR_RSV;
      POS_ID:             data_byte = servo_id_r;
      POS_LEN_LO:         data_byte = op_r ? LEN_WIDE : LEN_NARROW;
      POS_LEN_HI:         data_byte = LEN_HI;
      POS_INST:           data_byte = INST_WRITE;
      POS_ADDR_LO:        data_byte = addr_r[7:0];
      POS_ADDR_HI:        data_byte = addr_r[15:8];
      POS_VAL0:           data_byte = val_r[7:0];
      POS_VAL1:           data_byte = val_r[15:8];
      POS_VAL2:           data_byte = val_r[23:16];
      POS_VAL3:           data_byte = val_r[31:24];
      default:            data_byte = 8'h00;
    endcase
    if (!in_crc) cur_byte = data_byte;
    else if (idx_r == crc_pos) cur_byte = crc_r[7:0];
    else cur_byte = crc_r[15:8];
  end

  always_comb begin
    idx_nxt = idx_r;
    crc_nxt = crc_r;
    if (cmd.start) begin
      idx_nxt = '0;
      crc_nxt = CRC_INIT;
    end else if (cmd.load) begin
      idx_nxt = idx_r + 1'b1;
      if (!in_crc) crc_nxt = crc_step(crc_r, data_byte);
    end
  end

  assign out_tx_byte = tx_byte_r;
  assign out_last    = last_r;

`ifndef NO_ASSERTIONS
  a_final_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && sts.final_byte) |-> (idx_r == POS_END_NARROW || idx_r == POS_END_WIDE))
    else $error("packet ended at an unexpected byte position");
`endif

endmodule

// ===== src/servo_write_packet_framer_core.sv =====
// Servo write packet framer: one register-write command in, 13 or 16 packet bytes out.
// After the command beat the controller moves to send and loads the first byte into the output register.
// Then one byte per cycle unless out_ready stalls the output; a new command is taken once idle again.
// The CRC-16 is folded in one byte per cycle, when not stalled, as non-CRC bytes enter the output register.
// Reset (rst_n low, synchronous): controller idle, output empty, servo id 0.
`timescale 1ns / 1ps

module servo_write_packet_framer_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_servo_id,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic [15:0]        in_reg_address,
  input  logic signed [31:0] in_write_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_tx_byte,
  output logic               out_last
);
  import swpf_pkg::*;

  swpf_cmd_t cmd;
  swpf_sts_t sts;

  swpf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  swpf_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_servo_id   (cfg_servo_id),
    .in_op          (in_op),
    .in_reg_address (in_reg_address),
    .in_write_value (in_write_value),
    .out_tx_byte    (out_tx_byte),
    .out_last       (out_last),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule
